@@ design/apsfe_pkg.sv @@
package apsfe_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int BYTE_W         = 8;
  localparam int LEN_W          = 4;
  localparam int SAMPLE_BYTES   = 4;
  localparam int FRAME_BASE_LEN = 7;
  localparam int FRAME_MAX_LEN  = 11;

  // APB register map, one 32-bit register every four bytes
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_START  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_STOP   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_TYPE   = 2'd3;

  localparam logic [BYTE_W-1:0] START_RESET  = 8'd126;
  localparam logic [BYTE_W-1:0] STOP_RESET   = 8'd127;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;
  localparam logic [BYTE_W-1:0] TYPE_RESET   = 8'd13;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] stop_marker;
    logic [BYTE_W-1:0] escape_marker;
    logic [BYTE_W-1:0] frame_type;
  } cfg_t;

  // One classified sample pair: the four data bytes in send order, which of
  // them need an escape, and the resulting frame length.
  typedef struct packed {
    logic [SAMPLE_BYTES-1:0][BYTE_W-1:0] data;
    logic [SAMPLE_BYTES-1:0]             esc;
    logic [LEN_W-1:0]                    len;
  } desc_t;

endpackage

@@ design/apsfe_ifs.sv @@
interface apsfe_sample_if
  import apsfe_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] first_sample;
  logic [SAMPLE_W-1:0] second_sample;

  modport source (output valid, first_sample, second_sample, input ready);
  modport sink   (input valid, first_sample, second_sample, output ready);
endinterface

interface apsfe_byte_if
  import apsfe_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_byte;
  logic [LEN_W-1:0]  frame_length;

  modport source (output valid, out_byte, last_byte, frame_length, input ready);
  modport sink   (input valid, out_byte, last_byte, frame_length, output ready);
endinterface

@@ design/apsfe_front.sv @@
module apsfe_front
  import apsfe_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  apsfe_sample_if.sink  samples,
  output logic          desc_valid,
  output desc_t         desc,
  input  logic          desc_ready
);

  logic [SAMPLE_BYTES-1:0][BYTE_W-1:0] bytes;
  logic [SAMPLE_BYTES-1:0]             esc;
  desc_t                               desc_next;
  logic                                take;

  // first sample high byte goes out first
  assign bytes = {samples.second_sample[7:0], samples.second_sample[15:8],
                  samples.first_sample[7:0],  samples.first_sample[15:8]};

  always_comb begin
    for (int i = 0; i < SAMPLE_BYTES; i++) begin
      esc[i] = (bytes[i] == cfg.start_marker) || (bytes[i] == cfg.stop_marker) ||
               (bytes[i] == cfg.escape_marker);
    end
    desc_next.data = bytes;
    desc_next.esc  = esc;
    desc_next.len  = LEN_W'(FRAME_BASE_LEN) + LEN_W'($countones(esc));
  end

  assign samples.ready = !desc_valid || desc_ready;
  assign take          = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
    end else if (samples.ready) begin
      desc_valid <= samples.valid;
    end
    if (take) begin
      desc <= desc_next;
    end
  end

`ifndef SYNTHESIS
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    desc_valid |-> (desc.len >= LEN_W'(FRAME_BASE_LEN)) &&
                   (desc.len <= LEN_W'(FRAME_MAX_LEN)) &&
                   (desc.len == LEN_W'(FRAME_BASE_LEN) + LEN_W'($countones(desc.esc))))
    else $error("front: frame length out of range");
`endif

endmodule

@@ design/apsfe_queue.sv @@
module apsfe_queue
  import apsfe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  input  desc_t wr_desc,
  output logic  wr_ready,
  output logic  rd_valid,
  output desc_t rd_desc,
  input  logic  rd_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_desc  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= wr_desc;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (count == CNT_W'(DEPTH)) && !pop |=> (count == CNT_W'(DEPTH)) && !$past(push))
    else $error("queue: write taken while full");
`endif

endmodule

@@ design/apsfe_back.sv @@
module apsfe_back
  import apsfe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         q_valid,
  input  desc_t        q_desc,
  output logic         q_pop,
  apsfe_byte_if.source frame
);

  typedef enum logic [2:0] {
    P_START,
    P_TYPE,
    P_DATA,
    P_INV,
    P_STOP
  } pos_t;

  pos_t              pos;
  pos_t              pos_next;
  logic [1:0]        idx;
  logic [1:0]        idx_next;
  logic [BYTE_W-1:0] gen_byte;
  logic              gen_last;
  logic              load;

  // hold the output word until taken; refill it in the same cycle
  assign load  = !frame.valid || frame.ready;
  assign q_pop = load && q_valid && (pos == P_STOP);

  always_comb begin
    gen_byte = cfg.start_marker;
    gen_last = 1'b0;
    pos_next = pos;
    idx_next = idx;
    unique case (pos)
      P_START: begin
        gen_byte = cfg.start_marker;
        pos_next = P_TYPE;
      end
      P_TYPE: begin
        gen_byte = cfg.frame_type;
        pos_next = P_DATA;
        idx_next = '0;
      end
      P_DATA: begin
        if (q_desc.esc[idx]) begin
          gen_byte = cfg.escape_marker;
          pos_next = P_INV;
        end else begin
          gen_byte = q_desc.data[idx];
          pos_next = (idx == 2'(SAMPLE_BYTES - 1)) ? P_STOP : P_DATA;
          idx_next = idx + 1'b1;
        end
      end
      P_INV: begin
        gen_byte = ~q_desc.data[idx];
        pos_next = (idx == 2'(SAMPLE_BYTES - 1)) ? P_STOP : P_DATA;
        idx_next = idx + 1'b1;
      end
      P_STOP: begin
        gen_byte = cfg.stop_marker;
        gen_last = 1'b1;
        pos_next = P_START;
      end
      default: begin
        pos_next = P_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= P_START;
      idx         <= '0;
      frame.valid <= 1'b0;
    end else if (load) begin
      frame.valid <= q_valid;
      if (q_valid) begin
        pos <= pos_next;
        idx <= idx_next;
      end
    end
    if (load && q_valid) begin
      frame.out_byte     <= gen_byte;
      frame.last_byte    <= gen_last;
      frame.frame_length <= q_desc.len;
    end
  end

`ifndef SYNTHESIS
  a_head_held: assert property (@(posedge clk) disable iff (rst)
    (pos != P_START) |-> q_valid)
    else $error("back: queue head lost mid-frame");

  a_len_steady: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.ready && !frame.last_byte |=>
      frame.valid && (frame.frame_length == $past(frame.frame_length)))
    else $error("back: gap or length change inside a frame");

  a_last_is_stop: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.last_byte |-> (frame.out_byte == cfg.stop_marker))
    else $error("back: last word is not the stop marker");
`endif

endmodule

@@ design/adc_pair_stuffed_frame_encoder_top.sv @@
// Sample-pair frame encoder. Each word on the samples channel (two 16-bit ADC
// results) becomes one byte frame on the frame channel: start marker, frame
// type, the four sample bytes high byte first and first sample first, then
// the stop marker. A sample byte that equals the start, stop or escape marker
// goes out as the escape marker followed by the inverted byte; the type byte
// is never escaped. Frames are 7 to 11 bytes (7 plus one per escaped byte),
// and every byte carries the frame length and a last flag set on the stop
// marker. The output runs at one byte per cycle while the receiver is
// ready, paced by the single output byte register; frames follow each other
// back to back when the next pair is already queued. The front stage
// registers a classified sample pair, and a small queue (QUEUE_DEPTH words)
// lets it take the next pair while the back end is still sending. Markers
// and type are set over APB at byte addresses 0x0 (start), 0x4 (stop), 0x8
// (escape) and 0xC (type); write them only while no frame is in flight.
module adc_pair_stuffed_frame_encoder_top
  import apsfe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  apsfe_sample_if.sink          samples,
  apsfe_byte_if.source          frame,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t                 cfg;
  logic                 reg_write;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 desc_valid;
  desc_t                desc;
  logic                 desc_ready;
  logic                 q_valid;
  desc_t                q_desc;
  logic                 q_pop;

  // APB: zero wait states, register selected by the word address
  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker  <= START_RESET;
      cfg.stop_marker   <= STOP_RESET;
      cfg.escape_marker <= ESCAPE_RESET;
      cfg.frame_type    <= TYPE_RESET;
    end else if (reg_write) begin
      unique case (reg_idx)
        REG_START:  cfg.start_marker  <= pwdata[BYTE_W-1:0];
        REG_STOP:   cfg.stop_marker   <= pwdata[BYTE_W-1:0];
        REG_ESCAPE: cfg.escape_marker <= pwdata[BYTE_W-1:0];
        REG_TYPE:   cfg.frame_type    <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // return the selected register, zero-extended
  always_comb begin
    unique case (reg_idx)
      REG_START:  prdata = APB_DATA_W'(cfg.start_marker);
      REG_STOP:   prdata = APB_DATA_W'(cfg.stop_marker);
      REG_ESCAPE: prdata = APB_DATA_W'(cfg.escape_marker);
      REG_TYPE:   prdata = APB_DATA_W'(cfg.frame_type);
      default:    prdata = '0;
    endcase
  end

  // classify each sample byte and work out the frame length
  apsfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .samples    (samples),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_ready (desc_ready)
  );

  // decouple intake from byte output
  apsfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (desc_valid),
    .wr_desc  (desc),
    .wr_ready (desc_ready),
    .rd_valid (q_valid),
    .rd_desc  (q_desc),
    .rd_pop   (q_pop)
  );

  // one byte per cycle unless stalled; drop the queue head after the stop marker
  apsfe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_desc  (q_desc),
    .q_pop   (q_pop),
    .frame   (frame)
  );

endmodule

@@ sim/tb.sv @@
module tb;
  import apsfe_pkg::*;

  // One byte of an encoded frame as it should leave the block
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_byte;
    logic [LEN_W-1:0]  frame_length;
  } frame_byte_t;

  localparam int QUIET_LIMIT    = 4000;
  localparam int RANDOM_PER_SET = 58;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 24;

  // Mirror of the marker registers plus the bytes still owed by the block.
  // Each accepted sample pair is expanded into its stuffed frame right away.
  class frame_checker;
    logic [BYTE_W-1:0] start_mk;
    logic [BYTE_W-1:0] stop_mk;
    logic [BYTE_W-1:0] escape_mk;
    logic [BYTE_W-1:0] type_byte;
    frame_byte_t       owed_bytes[$];
    int                errors;

    function new();
      start_mk  = START_RESET;
      stop_mk   = STOP_RESET;
      escape_mk = ESCAPE_RESET;
      type_byte = TYPE_RESET;
      errors    = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
      case (idx)
        REG_START:  start_mk  = val;
        REG_STOP:   stop_mk   = val;
        REG_ESCAPE: escape_mk = val;
        REG_TYPE:   type_byte = val;
        default: ;
      endcase
    endfunction

    function bit is_marker(logic [BYTE_W-1:0] b);
      return b == start_mk || b == stop_mk || b == escape_mk;
    endfunction

    function int pending();
      return owed_bytes.size();
    endfunction

    function void take_pair(logic [SAMPLE_W-1:0] first_s, logic [SAMPLE_W-1:0] second_s);
      logic [BYTE_W-1:0] data[SAMPLE_BYTES];
      logic [BYTE_W-1:0] frame_bytes[$];
      frame_byte_t       fb;
      data[0] = first_s[15:8];
      data[1] = first_s[7:0];
      data[2] = second_s[15:8];
      data[3] = second_s[7:0];
      frame_bytes.push_back(start_mk);
      frame_bytes.push_back(type_byte);
      for (int i = 0; i < SAMPLE_BYTES; i++) begin
        if (is_marker(data[i])) begin
          frame_bytes.push_back(escape_mk);
          frame_bytes.push_back(~data[i]);
        end else begin
          frame_bytes.push_back(data[i]);
        end
      end
      frame_bytes.push_back(stop_mk);
      for (int i = 0; i < frame_bytes.size(); i++) begin
        fb.out_byte     = frame_bytes[i];
        fb.last_byte    = (i == frame_bytes.size() - 1);
        fb.frame_length = LEN_W'(frame_bytes.size());
        owed_bytes.push_back(fb);
      end
    endfunction

    function void check_byte(frame_byte_t got);
      frame_byte_t want;
      if (owed_bytes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected frame byte %02h last %0b len %0d",
                   got.out_byte, got.last_byte, got.frame_length);
        return;
      end
      want = owed_bytes.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("frame byte mismatch: expected %02h last %0b len %0d, got %02h last %0b len %0d",
                   want.out_byte, want.last_byte, want.frame_length,
                   got.out_byte, got.last_byte, got.frame_length);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  apsfe_sample_if samples();
  apsfe_byte_if   frame();

  adc_pair_stuffed_frame_encoder_top dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .frame   (frame),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  frame_checker checker_h = new();

  int send_idle_pct;
  int recv_idle_pct;
  int pairs_taken;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver side: drop ready at random, at the rate of the current profile
  always @(negedge clk) begin
    frame.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // Observe both channels at the rising edge; inputs only move at the falling
  // edge, so everything sampled here is settled. Count cycles without any
  // accepted word and give up once the block has gone quiet for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if (samples.valid && samples.ready) begin
        checker_h.take_pair(samples.first_sample, samples.second_sample);
        pairs_taken++;
      end
      if (frame.valid && frame.ready)
        checker_h.check_byte({frame.out_byte, frame.last_byte, frame.frame_length});
      if ((samples.valid && samples.ready) || (frame.valid && frame.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // Offer one sample pair. Call at a falling edge; return at the falling edge
  // right after the word was taken, with valid still high so that a
  // back-to-back word needs no gap.
  task automatic send_pair(input logic [SAMPLE_W-1:0] first_s,
                           input logic [SAMPLE_W-1:0] second_s);
    int taken_before;
    while ($urandom_range(99) < send_idle_pct) begin
      samples.valid <= 1'b0;
      @(negedge clk);
    end
    taken_before = pairs_taken;
    samples.valid         <= 1'b1;
    samples.first_sample  <= first_s;
    samples.second_sample <= second_s;
    do @(negedge clk); while (pairs_taken == taken_before);
  endtask

  // Hold the sender off until every owed byte has come out, then let the
  // pipeline settle.
  task automatic drain_frames();
    samples.valid <= 1'b0;
    while (checker_h.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high. Junk
  // in the upper data bits must be ignored by the block.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx) << 2;
    pwdata  <= {24'($urandom()), val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    checker_h.set_reg(idx, val);
  endtask

  task automatic write_markers(input logic [BYTE_W-1:0] start_v, input logic [BYTE_W-1:0] stop_v,
                               input logic [BYTE_W-1:0] escape_v, input logic [BYTE_W-1:0] type_v);
    write_reg(REG_START, start_v);
    write_reg(REG_STOP, stop_v);
    write_reg(REG_ESCAPE, escape_v);
    write_reg(REG_TYPE, type_v);
  endtask

  // Bias sample bytes toward the markers, their inverses and the type byte,
  // so that stuffing and its corner cases come up often.
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(9))
      0: return checker_h.start_mk;
      1: return checker_h.stop_mk;
      2: return checker_h.escape_mk;
      3: begin
        case ($urandom_range(2))
          0: return ~checker_h.start_mk;
          1: return ~checker_h.stop_mk;
          default: return ~checker_h.escape_mk;
        endcase
      end
      4: return checker_h.type_byte;
      default: return BYTE_W'($urandom());
    endcase
  endfunction

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    samples.valid         = 1'b0;
    samples.first_sample  = '0;
    samples.second_sample = '0;
    frame.ready      = 1'b0;
    pairs_taken      = 0;
    quiet_cycles     = 0;
    send_idle_pct    = 33;
    recv_idle_pct    = 57;

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Six marker settings; the idle profile advances every two of them:
    // sender-light/receiver-heavy, then swapped, then no idling at all.
    for (int set_no = 0; set_no < 6; set_no++) begin
      case (set_no / 2)
        0: begin send_idle_pct = 33; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase

      if (set_no > 0) begin
        drain_frames();
        case (set_no)
          // Extremes; type equal to the start marker, and the start
          // marker's inverse equal to the stop marker.
          1: write_markers(8'h00, 8'hFF, 8'h01, 8'h00);
          // All three markers and the type collapse onto one value
          2: write_markers(8'h55, 8'h55, 8'h55, 8'h55);
          4: write_markers(8'hFF, 8'h00, 8'hFE, 8'hFF);
          default: write_markers(BYTE_W'($urandom()), BYTE_W'($urandom()),
                                 BYTE_W'($urandom()), BYTE_W'($urandom()));
        endcase
      end

      // Directed words for this setting
      case (set_no)
        0: begin
          send_pair(16'h0000, 16'h0000);
          send_pair(16'hFFFF, 16'hFFFF);
          send_pair(16'h7E7F, 16'h7D0D);   // every data byte but one escaped
          send_pair(16'h7E7E, 16'h7E7E);   // longest frame
          send_pair(16'h8180, 16'h8200);   // inverted markers pass untouched
          send_pair(16'h0D0D, 16'h7D7D);   // type value in data is plain data
          send_pair(16'h0102, 16'h0408);
          send_pair(16'h1020, 16'h4080);
          send_pair(16'hFEFD, 16'hFBF7);
          send_pair(16'hEFDF, 16'hBF7F);
        end
        1: begin
          send_pair(16'h00FF, 16'h01FE);   // escaped byte inverts to a marker
          send_pair(16'h0000, 16'h0000);
          send_pair(16'hFFFF, 16'h0101);
        end
        2: begin
          send_pair(16'h5555, 16'hAA55);
          send_pair(16'hAAAA, 16'hAAAA);
        end
        4: send_pair(16'hFF00, 16'hFE01);
        default: ;
      endcase

      // Random words: mostly stuffing-heavy content, some fully random
      for (int n = 0; n < RANDOM_PER_SET; n++) begin
        if ($urandom_range(3) == 0)
          send_pair(SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
        else
          send_pair({pick_byte(), pick_byte()}, {pick_byte(), pick_byte()});
      end
    end

    // Back to the reset values so every register sees one more write
    drain_frames();
    write_markers(START_RESET, STOP_RESET, ESCAPE_RESET, TYPE_RESET);
    for (int n = 0; n < 8; n++)
      send_pair({pick_byte(), pick_byte()}, {pick_byte(), pick_byte()});

    samples.valid <= 1'b0;
    while (checker_h.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (checker_h.errors == 0 && checker_h.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
